[hw/rtl/pgf_pkg.sv]
package pgf_pkg;

    localparam int POS_W    = 24;
    localparam int MASS_W   = 24;
    localparam int D_W      = POS_W + 1;
    localparam int MAG_W    = D_W;
    localparam int DSQ_W    = 2 * D_W;
    localparam int LEN_W    = DSQ_W / 2;
    localparam int U_SH     = 30;
    localparam int U_W      = U_SH + 1;
    localparam int PC_W     = 2 * MASS_W;
    localparam int DEN_W    = PC_W + DSQ_W;
    localparam int G_W      = 32;
    localparam int PROD_W   = G_W + U_W;
    localparam int F_SH     = 26;
    localparam int NUM_W    = PROD_W + F_SH;
    localparam int F_W      = 32;
    localparam int RANGE_W  = 25;
    localparam int SQRT_LAT = LEN_W;
    localparam int UDIV_LAT = U_W;
    localparam int FDIV_LAT = F_W + 1;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [G_W-1:0] STRENGTH_RST = 32'h0001_0000;
    localparam logic [F_W-1:0] SAT_POS      = 32'h7FFF_FFFF;
    localparam logic [F_W-1:0] SAT_NEG      = 32'h8000_0000;

    typedef enum logic [1:0] {
        REG_STRENGTH = 2'd0,
        REG_INNER    = 2'd1,
        REG_OUTER    = 2'd2
    } pgf_reg_e;

    typedef struct packed {
        logic signed [POS_W-1:0] center_x;
        logic signed [POS_W-1:0] center_y;
        logic signed [POS_W-1:0] center_z;
        logic        [MASS_W-1:0] center_inv_mass;
        logic signed [POS_W-1:0] particle_x;
        logic signed [POS_W-1:0] particle_y;
        logic signed [POS_W-1:0] particle_z;
        logic        [MASS_W-1:0] particle_inv_mass;
    } pgf_in_t;

    typedef struct packed {
        logic signed [F_W-1:0] force_x;
        logic signed [F_W-1:0] force_y;
        logic signed [F_W-1:0] force_z;
        logic                  applied;
    } pgf_out_t;

endpackage

[hw/rtl/pgf_delay.sv]
module pgf_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) line_reg[i] <= '0;
        end else if (en) begin
            line_reg[0] <= din;
            for (int i = 1; i < N; i++) line_reg[i] <= line_reg[i-1];
        end
    end

    assign dout = line_reg[N-1];

endmodule

[hw/rtl/pgf_sqrt.sv]
module pgf_sqrt import pgf_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [DSQ_W-1:0] dsq,
    output logic [LEN_W-1:0] root
);

    localparam int SW = DSQ_W + 1;

    logic [SW-1:0]    rem_reg  [LEN_W-1];
    logic [LEN_W-1:0] root_reg [LEN_W];

    for (genvar j = 0; j < LEN_W; j++) begin : g_stage
        localparam int K = LEN_W - 1 - j;
        logic [SW-1:0]    rem_in;
        logic [SW-1:0]    trial;
        logic [LEN_W-1:0] root_in;
        logic             take;

        if (j == 0) begin : g_first
            assign rem_in  = SW'(dsq);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
        assign trial = (SW'(root_in) << (K + 1)) | (SW'(1) << (2 * K));
        assign take  = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (en) root_reg[j] <= take ? (root_in | (LEN_W'(1) << K)) : root_in;
        end

        if (j < LEN_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) rem_reg[j] <= take ? (rem_in - trial) : rem_in;
            end
        end
    end

    assign root = root_reg[LEN_W-1];

endmodule

[hw/rtl/pgf_udiv.sv]
module pgf_udiv import pgf_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [MAG_W-1:0] mag,
    input  logic [LEN_W-1:0] len,
    output logic [U_W-1:0]   unit
);

    localparam int RW = MAG_W + U_W;

    logic [RW-1:0]    rem_reg [U_W-1];
    logic [LEN_W-1:0] div_reg [U_W-1];
    logic [U_W-1:0]   q_reg   [U_W];

    for (genvar j = 0; j < U_W; j++) begin : g_stage
        localparam int K = U_W - 1 - j;
        logic [RW-1:0]    rem_in;
        logic [RW-1:0]    trial;
        logic [LEN_W-1:0] div_in;
        logic [U_W-1:0]   q_in;
        logic             take;

        if (j == 0) begin : g_first
            assign rem_in = RW'(mag) << U_SH;
            assign div_in = len;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign div_in = div_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign trial = RW'(div_in) << K;
        assign take  = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (en) q_reg[j] <= take ? (q_in | (U_W'(1) << K)) : q_in;
        end

        if (j < U_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= take ? (rem_in - trial) : rem_in;
                    div_reg[j] <= div_in;
                end
            end
        end
    end

    assign unit = q_reg[U_W-1];

endmodule

[hw/rtl/pgf_fdiv.sv]
module pgf_fdiv import pgf_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [PROD_W-1:0] prod,
    input  logic [DEN_W-1:0]  den,
    input  logic              neg,
    output logic [F_W-1:0]    force_val
);

    localparam int CW = DEN_W + F_W;

    logic [NUM_W-1:0] rem_reg  [F_W];
    logic [DEN_W-1:0] den_reg  [F_W];
    logic [F_W-1:0]   q_reg    [1:F_W];
    logic             ovf_reg  [F_W+1];
    logic             zero_reg [F_W+1];
    logic             neg_reg  [F_W+1];

    logic [NUM_W-1:0] num;
    logic [F_W-1:0]   q;
    logic [F_W-1:0]   lim;
    logic             sat;

    assign num = NUM_W'(prod) << F_SH;

    // quotient of 2^32 or more saturates; a zero divisor lands here too
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            ovf_reg[0]  <= CW'(num) >= (CW'(den) << F_W);
            zero_reg[0] <= prod == '0;
            neg_reg[0]  <= neg;
        end
    end

    for (genvar j = 1; j <= F_W; j++) begin : g_stage
        localparam int K = F_W - j;
        logic [CW-1:0]  trial;
        logic [F_W-1:0] q_in;
        logic           take;

        if (j == 1) begin : g_first
            assign q_in = '0;
        end else begin : g_next
            assign q_in = q_reg[j-1];
        end

        assign trial = CW'(den_reg[j-1]) << K;
        assign take  = CW'(rem_reg[j-1]) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j]    <= take ? (q_in | (F_W'(1) << K)) : q_in;
                ovf_reg[j]  <= ovf_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
            end
        end

        if (j < F_W) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= take ? NUM_W'(CW'(rem_reg[j-1]) - trial) : rem_reg[j-1];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign q   = q_reg[F_W];
    assign lim = neg_reg[F_W] ? SAT_NEG : SAT_POS;
    assign sat = ovf_reg[F_W] || (q > lim);

    always_comb begin
        if (zero_reg[F_W])     force_val = '0;
        else if (sat)          force_val = lim;
        else if (neg_reg[F_W]) force_val = F_W'(-q);
        else                   force_val = q;
    end

endmodule

[hw/rtl/point_gravity_force_core.sv]
// Channel  | Ports                               | Carries
// ---------+-------------------------------------+---------------------------------
// input    | s_valid, s_ready, s_item            | particle and centre of gravity
// result   | m_valid, m_ready, m_item            | force x/y/z Q16.16, applied flag
// config   | psel, penable, pwrite, paddr, ...   | strength, inner and outer range
//
// One transfer is taken per cycle while s_ready is high; each item passes through
// four front stages, a 25-stage square root, a 31-stage unit divider, the strength
// multiply, a 33-stage force divider and the output register.
// Reset clears valid bits and loads the registers with their reset values.
// A waiting result parks in a one-entry skid register; only while that entry is
// full does the pipeline hold and s_ready drop, so no item is lost or repeated.
module point_gravity_force_core import pgf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pgf_in_t           s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output pgf_out_t          m_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int MAG_DLY  = SQRT_LAT;
    localparam int NEG_DLY  = SQRT_LAT + UDIV_LAT + 1;
    localparam int DEN_DLY  = NEG_DLY - 2;
    localparam int FLAG_DLY = NEG_DLY + FDIV_LAT;

    // Configuration registers and their squares
    logic [G_W-1:0]     strength_reg;
    logic [RANGE_W-1:0] inner_reg;
    logic [RANGE_W-1:0] outer_reg;
    logic [DSQ_W-1:0]   inner_sq_reg;
    logic [DSQ_W-1:0]   outer_sq_reg;
    pgf_reg_e           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = pgf_reg_e'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg <= STRENGTH_RST;
            inner_reg    <= '0;
            outer_reg    <= '0;
            inner_sq_reg <= '0;
            outer_sq_reg <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                case (cfg_idx)
                    REG_STRENGTH: strength_reg <= pwdata;
                    REG_INNER:    inner_reg    <= pwdata[RANGE_W-1:0];
                    REG_OUTER:    outer_reg    <= pwdata[RANGE_W-1:0];
                    default:      ;
                endcase
            end
            inner_sq_reg <= DSQ_W'(inner_reg) * DSQ_W'(inner_reg);
            outer_sq_reg <= DSQ_W'(outer_reg) * DSQ_W'(outer_reg);
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_STRENGTH: prdata = strength_reg;
            REG_INNER:    prdata = APB_DW'(inner_reg);
            REG_OUTER:    prdata = APB_DW'(outer_reg);
            default:      prdata = '0;
        endcase
    end

    // Pipeline advance: hold every stage before the output register only while the skid entry is full
    logic en;
    logic skid_vld_reg;

    assign en      = !skid_vld_reg;
    assign s_ready = en;

    logic [4:1] vld_reg;

    // Stage 1: axis differences
    logic signed [D_W-1:0]  d1_reg [3];
    logic [MASS_W-1:0]      pinv1_reg;
    logic [MASS_W-1:0]      cinv1_reg;

    // Stage 2: squares, mass product
    logic signed [DSQ_W-1:0] sq_w [3];
    logic [DSQ_W-1:0]        sq2_reg [3];
    logic signed [D_W-1:0]   d2_reg  [3];
    logic [PC_W-1:0]         pc2_reg;
    logic                    inf2_reg;

    // Stage 3: squared distance
    logic [DSQ_W-1:0]        dsq3_reg;
    logic signed [D_W-1:0]   d3_reg [3];
    logic [PC_W-1:0]         pc3_reg;
    logic                    inf3_reg;

    // Stage 4: range checks, clamped distance, magnitudes
    logic [DSQ_W-1:0]        dsq4_reg;
    logic [DSQ_W-1:0]        eff4_reg;
    logic [PC_W-1:0]         pc4_reg;
    logic [MAG_W-1:0]        mag4_reg [3];
    logic [2:0]              neg4_reg;
    logic                    skip4_reg;
    logic                    zero4_reg;

    for (genvar i = 0; i < 3; i++) begin : g_sq
        assign sq_w[i] = d1_reg[i] * d1_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:1], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg[0] <= D_W'(s_item.center_x) - D_W'(s_item.particle_x);
            d1_reg[1] <= D_W'(s_item.center_y) - D_W'(s_item.particle_y);
            d1_reg[2] <= D_W'(s_item.center_z) - D_W'(s_item.particle_z);
            pinv1_reg <= s_item.particle_inv_mass;
            cinv1_reg <= s_item.center_inv_mass;

            for (int i = 0; i < 3; i++) begin
                sq2_reg[i] <= $unsigned(sq_w[i]);
                d2_reg[i]  <= d1_reg[i];
                d3_reg[i]  <= d2_reg[i];
                neg4_reg[i] <= d3_reg[i][D_W-1];
                mag4_reg[i] <= d3_reg[i][D_W-1] ? MAG_W'(-d3_reg[i]) : MAG_W'(d3_reg[i]);
            end
            pc2_reg  <= PC_W'(pinv1_reg) * PC_W'(cinv1_reg);
            inf2_reg <= pinv1_reg == '0;

            dsq3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            pc3_reg  <= pc2_reg;
            inf3_reg <= inf2_reg;

            dsq4_reg  <= dsq3_reg;
            eff4_reg  <= (dsq3_reg < inner_sq_reg) ? inner_sq_reg : dsq3_reg;
            pc4_reg   <= pc3_reg;
            skip4_reg <= inf3_reg || ((outer_reg != '0) && (dsq3_reg > outer_sq_reg));
            zero4_reg <= dsq3_reg == '0;
        end
    end

    // Denominator pinv*cinv*eff: four partial products, then one sum
    localparam int PC_H = PC_W / 2;
    localparam int E_H  = DSQ_W / 2;

    logic [PC_H+E_H-1:0] pp_reg [4];
    logic [DEN_W-1:0]    den6_reg;
    logic [DEN_W-1:0]    den_dly;

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg[0] <= (PC_H+E_H)'(pc4_reg[PC_H-1:0])    * (PC_H+E_H)'(eff4_reg[E_H-1:0]);
            pp_reg[1] <= (PC_H+E_H)'(pc4_reg[PC_H-1:0])    * (PC_H+E_H)'(eff4_reg[DSQ_W-1:E_H]);
            pp_reg[2] <= (PC_H+E_H)'(pc4_reg[PC_W-1:PC_H]) * (PC_H+E_H)'(eff4_reg[E_H-1:0]);
            pp_reg[3] <= (PC_H+E_H)'(pc4_reg[PC_W-1:PC_H]) * (PC_H+E_H)'(eff4_reg[DSQ_W-1:E_H]);
            den6_reg  <= DEN_W'(pp_reg[0])
                       + (DEN_W'(pp_reg[1]) << E_H)
                       + (DEN_W'(pp_reg[2]) << PC_H)
                       + (DEN_W'(pp_reg[3]) << (PC_H + E_H));
        end
    end

    pgf_delay #(.W(DEN_W), .N(DEN_DLY)) u_den_dly (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(den6_reg), .dout(den_dly)
    );

    // True distance
    logic [LEN_W-1:0] len;

    pgf_sqrt u_sqrt (.aclk(aclk), .en(en), .dsq(dsq4_reg), .root(len));

    // Flags travel alongside the whole datapath
    logic [2:0] flags_dly;

    pgf_delay #(.W(3), .N(FLAG_DLY)) u_flag_dly (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .din({vld_reg[4], skip4_reg, zero4_reg}), .dout(flags_dly)
    );

    // Per axis: unit vector, strength product, force quotient
    logic [F_W-1:0]    force_w [3];
    logic [PROD_W-1:0] prod_reg [3];

    for (genvar i = 0; i < 3; i++) begin : g_axis
        logic [MAG_W-1:0] mag_dly;
        logic             neg_dly;
        logic [U_W-1:0]   unit;

        pgf_delay #(.W(MAG_W), .N(MAG_DLY)) u_mag_dly (
            .aclk(aclk), .aresetn(aresetn), .en(en), .din(mag4_reg[i]), .dout(mag_dly)
        );

        pgf_delay #(.W(1), .N(NEG_DLY)) u_neg_dly (
            .aclk(aclk), .aresetn(aresetn), .en(en), .din(neg4_reg[i]), .dout(neg_dly)
        );

        pgf_udiv u_udiv (.aclk(aclk), .en(en), .mag(mag_dly), .len(len), .unit(unit));

        always_ff @(posedge aclk) begin
            if (en) prod_reg[i] <= PROD_W'(strength_reg) * PROD_W'(unit);
        end

        pgf_fdiv u_fdiv (
            .aclk(aclk), .en(en), .prod(prod_reg[i]), .den(den_dly),
            .neg(neg_dly), .force_val(force_w[i])
        );
    end

    // Last stage result
    pgf_out_t p_item;
    logic     last_vld;
    logic     blank;

    assign last_vld = flags_dly[2];
    assign blank    = flags_dly[1] || flags_dly[0];

    always_comb begin
        p_item.force_x = blank ? '0 : force_w[0];
        p_item.force_y = blank ? '0 : force_w[1];
        p_item.force_z = blank ? '0 : force_w[2];
        p_item.applied = !flags_dly[1];
    end

    // Output register with one skid entry
    logic     m_valid_reg;
    pgf_out_t m_item_reg;
    pgf_out_t skid_item_reg;
    logic     take;
    logic     p_move;

    assign take   = m_ready || !m_valid_reg;
    assign p_move = en && last_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg  <= skid_vld_reg || p_move;
            skid_vld_reg <= 1'b0;
        end else if (p_move) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_item_reg <= skid_vld_reg ? skid_item_reg : p_item;
        end else if (p_move) begin
            skid_item_reg <= p_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid_reg)
        else $error("skid entry full while output register empty");

    a_skip_no_force: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_item_reg.applied) |->
        (m_item_reg.force_x == '0 && m_item_reg.force_y == '0 && m_item_reg.force_z == '0))
        else $error("force given for a skipped particle");

    a_stall_parks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && p_move) |=> skid_vld_reg)
        else $error("result dropped during output stall");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !skid_vld_reg))
        else $error("result valid after reset");
`endif

endmodule
